// ===== hw/rtl/sapq_pkg.sv =====
// ----------------------------------------------------------------------------
// sapq_pkg
// Shared types and constants for the slot-array max priority queue.
// ----------------------------------------------------------------------------
package sapq_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int DATA_W    = 32;

  typedef enum logic [0:0] {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_kind_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_NULL  = 2'd3
  } status_t;

  typedef struct packed {
    op_kind_t                  kind;
    logic [DATA_W-1:0]         payload;
    logic signed [DATA_W-1:0]  priority_req;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] out_payload;
    status_t           status;
  } out_item_t;

  // Operation wavefront handed from cell to cell.
  // Insert: payload/prio carry the new entry, hit marks "already placed".
  // Delete: payload/prio carry the best entry so far, hit marks "found one".
  typedef struct packed {
    logic                      valid;
    op_kind_t                  kind;
    logic                      null_f;
    logic                      hit;
    logic [DATA_W-1:0]         payload;
    logic signed [DATA_W-1:0]  prio;
  } wave_t;

endpackage

// ===== hw/rtl/sapq_cell.sv =====
// ----------------------------------------------------------------------------
// sapq_cell
// One queue slot: holds used flag, payload and priority, and passes the
// operation wavefront on to the next slot through its wave register.
// ----------------------------------------------------------------------------
module sapq_cell #(
  parameter int IW    = 4,
  parameter int INDEX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sapq_pkg::wave_t   wave_i,
  input  logic [IW-1:0]     idx_i,
  input  logic              clr_en,
  input  logic [IW-1:0]     clr_idx,
  output sapq_pkg::wave_t   wave_o,
  output logic [IW-1:0]     idx_o
);
  import sapq_pkg::*;

  localparam logic [IW-1:0] MY_IDX = IW'(INDEX);

  logic                     used_r, used_nxt;
  logic [DATA_W-1:0]        pay_r, pay_nxt;
  logic signed [DATA_W-1:0] pri_r, pri_nxt;
  wave_t                    wave_r, wave_nxt;
  logic [IW-1:0]            idx_r, idx_nxt;

  always_comb begin
    wave_nxt = wave_i;
    idx_nxt  = idx_i;
    used_nxt = used_r;
    pay_nxt  = pay_r;
    pri_nxt  = pri_r;
    if (wave_i.valid) begin
      case (wave_i.kind)
        OP_INSERT: begin
          // first free slot takes the entry
          if (!used_r && !wave_i.hit && !wave_i.null_f) begin
            used_nxt     = 1'b1;
            pay_nxt      = wave_i.payload;
            pri_nxt      = wave_i.prio;
            wave_nxt.hit = 1'b1;
          end
        end
        OP_DELETE: begin
          // >= so that the highest-numbered slot wins a tie
          if (used_r && (!wave_i.hit || (pri_r >= wave_i.prio))) begin
            wave_nxt.payload = pay_r;
            wave_nxt.prio    = pri_r;
            wave_nxt.hit     = 1'b1;
            idx_nxt          = MY_IDX;
          end
        end
        default: begin
          wave_nxt = wave_i;
        end
      endcase
    end
    if (clr_en && (clr_idx == MY_IDX)) begin
      used_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      wave_r <= '0;
    end else begin
      used_r <= used_nxt;
      wave_r <= wave_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pay_r <= pay_nxt;
    pri_r <= pri_nxt;
    idx_r <= idx_nxt;
  end

  assign wave_o = wave_r;
  assign idx_o  = idx_r;

endmodule

// ===== hw/rtl/slot_array_max_priority_queue_core.sv =====
// ----------------------------------------------------------------------------
// slot_array_max_priority_queue_core
// Fixed-size max priority queue built as a chain of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (in_valid / in_stall / in_data): one transaction is one
//    operation, insert (payload + signed Q16.16 priority) or delete-max.
//  - Output channel (out_valid / out_stall / out_data): exactly one result
//    transaction per operation, in order: removed payload and a status
//    (ok, empty on delete, full on insert, null payload rejected).
//  - An operation travels down the cell chain one slot per cycle; insert
//    claims the lowest free slot, delete-max carries the best entry seen so
//    far and clears the winner when the wavefront leaves the last slot.
//  - One operation is in the chain at a time, so throughput is set by the
//    length of the slot chain.
//  - A finished result sits in the output register; the next operation is
//    accepted meanwhile. If the receiver still stalls when that next one
//    completes, it waits in a hold register and in_stall stays high.
//  - Reset (rst_n low, synchronous) frees every slot and empties the output;
//    there is no clearing pass.
// ----------------------------------------------------------------------------
module slot_array_max_priority_queue_core #(
  parameter int SLOTS = sapq_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sapq_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sapq_pkg::out_item_t out_data
);
  import sapq_pkg::*;

  localparam int IW = $clog2(SLOTS);

  // wavefront between cells; entry [0] is the incoming operation
  wave_t         wave [0:SLOTS];
  logic [IW-1:0] widx [0:SLOTS];

  logic          accept;
  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_item_t     out_data_r, out_data_nxt;
  logic          hold_valid_r, hold_valid_nxt;
  out_item_t     hold_data_r, hold_data_nxt;

  logic          exit_vld;
  logic          clr_en;
  logic [IW-1:0] clr_idx;
  logic          out_free;
  out_item_t     res;

  assign in_stall = busy_r;
  assign accept   = in_valid && !busy_r;

  assign wave[0].valid   = accept;
  assign wave[0].kind    = in_data.kind;
  assign wave[0].null_f  = (in_data.payload == '0);
  assign wave[0].hit     = 1'b0;
  assign wave[0].payload = in_data.payload;
  assign wave[0].prio    = in_data.priority_req;
  assign widx[0]         = '0;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    sapq_cell #(
      .IW    (IW),
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .wave_i  (wave[g]),
      .idx_i   (widx[g]),
      .clr_en  (clr_en),
      .clr_idx (clr_idx),
      .wave_o  (wave[g+1]),
      .idx_o   (widx[g+1])
    );
  end

  // wavefront leaving the last slot: finish the operation
  assign exit_vld = wave[SLOTS].valid;
  assign clr_en   = exit_vld && (wave[SLOTS].kind == OP_DELETE) && wave[SLOTS].hit;
  assign clr_idx  = widx[SLOTS];

  always_comb begin
    res.out_payload = '0;
    res.status      = ST_OK;
    case (wave[SLOTS].kind)
      OP_INSERT: begin
        if (wave[SLOTS].null_f) begin
          res.status = ST_NULL;
        end else if (!wave[SLOTS].hit) begin
          res.status = ST_FULL;
        end
      end
      OP_DELETE: begin
        if (wave[SLOTS].hit) begin
          res.out_payload = wave[SLOTS].payload;
        end else begin
          res.status = ST_EMPTY;
        end
      end
      default: begin
        res.status = ST_OK;
      end
    endcase
  end

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    busy_nxt       = busy_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    hold_valid_nxt = hold_valid_r;
    hold_data_nxt  = hold_data_r;
    if (accept) begin
      busy_nxt = 1'b1;
    end
    if (hold_valid_r && out_free) begin
      out_valid_nxt  = 1'b1;
      out_data_nxt   = hold_data_r;
      hold_valid_nxt = 1'b0;
      busy_nxt       = 1'b0;
    end else if (exit_vld && out_free) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
      busy_nxt      = 1'b0;
    end else if (exit_vld) begin
      hold_valid_nxt = 1'b1;
      hold_data_nxt  = res;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      busy_r       <= busy_nxt;
      out_valid_r  <= out_valid_nxt;
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r  <= out_data_nxt;
    hold_data_r <= hold_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // an operation in the chain always owns the busy flag
  a_exit_busy : assert property (@(posedge clk) disable iff (!rst_n)
    exit_vld |-> busy_r)
    else $error("wavefront left the chain with no operation pending");

  // a held result and a fresh wavefront never meet
  a_hold_excl : assert property (@(posedge clk) disable iff (!rst_n)
    !(hold_valid_r && exit_vld))
    else $error("result hold register overrun");

  // only a successful delete carries a payload
  a_pay_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r.status != ST_OK)) |-> (out_data_r.out_payload == '0))
    else $error("nonzero payload on failed operation");

  // accepted operation keeps the input closed next cycle
  a_acc_busy : assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> in_stall)
    else $error("second operation accepted while one is in the chain");

endmodule

// ===== sim/sapq_checker.sv =====
// ----------------------------------------------------------------------------
// sapq_checker
// Watches both channels of the slot-array priority queue, keeps its own copy
// of the slot table, and compares every result transaction in order.
// ----------------------------------------------------------------------------
module sapq_checker #(
  parameter int SLOTS = sapq_pkg::SLOTS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_stall,
  input  sapq_pkg::in_item_t  in_data,
  input  logic                out_valid,
  input  logic                out_stall,
  input  sapq_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  pending
);
  import sapq_pkg::*;

  // Shadow slot table
  logic                     shadow_used    [SLOTS];
  logic [DATA_W-1:0]        shadow_payload [SLOTS];
  logic signed [DATA_W-1:0] shadow_prio    [SLOTS];

  out_item_t due_results_q[$];
  int        mismatches = 0;

  // Applies one operation to the shadow table and returns its result.
  function automatic out_item_t run_queue_op(input in_item_t op);
    out_item_t res;
    int        pick;
    res.out_payload = '0;
    res.status      = ST_OK;
    pick            = -1;
    if (op.kind == OP_INSERT) begin
      if (op.payload == '0) begin
        res.status = ST_NULL;
      end else begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!shadow_used[i] && pick < 0) pick = i;
        end
        if (pick < 0) begin
          res.status = ST_FULL;
        end else begin
          shadow_used[pick]    = 1'b1;
          shadow_payload[pick] = op.payload;
          shadow_prio[pick]    = op.priority_req;
        end
      end
    end else begin
      // >= lets the higher slot win a tie
      for (int i = 0; i < SLOTS; i++) begin
        if (shadow_used[i] && (pick < 0 || shadow_prio[i] >= shadow_prio[pick])) pick = i;
      end
      if (pick < 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.out_payload   = shadow_payload[pick];
        shadow_used[pick] = 1'b0;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) shadow_used[i] = 1'b0;
      due_results_q.delete();
    end else begin
      // retire first: a result never belongs to an operation taken this edge
      if (out_valid && !out_stall) begin
        if (due_results_q.size() == 0) begin
          $error("unexpected result: out_payload %h status %0d",
                 out_data.out_payload, out_data.status);
          mismatches++;
        end else begin
          want = due_results_q.pop_front();
          if (out_data.out_payload !== want.out_payload) begin
            $error("out_payload: expected %h, got %h", want.out_payload, out_data.out_payload);
            mismatches++;
          end
          if (out_data.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_data.status);
            mismatches++;
          end
        end
      end
      if (in_valid && !in_stall) due_results_q.push_back(run_queue_op(in_data));
    end
    pending    <= due_results_q.size();
    fail_count <= mismatches;
  end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the slot-array max priority queue: a directed opening that
// fills, overfills and partly drains the table, then random insert/delete
// traffic with shifting fill bias and random idling on both channels.
// Checking is done by sapq_checker.
// ----------------------------------------------------------------------------
module tb_top;
  import sapq_pkg::*;

  localparam int SLOTS     = SLOTS_DEF;
  localparam int RAND_OPS  = 1025;
  localparam int BLOCK_LEN = 50;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  int fail_count;
  int pending;

  // receiver behavior, steered by the stimulus process
  logic        rx_quiet = 1'b0;
  int unsigned rx_hold  = 0;
  bit          tx_quiet = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  slot_array_max_priority_queue_core #(
    .SLOTS(SLOTS)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  sapq_checker #(
    .SLOTS(SLOTS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // Idle run length: mostly short, now and then long.
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 2);
    if (r < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // Priorities: many small Q16.16 values so ties are common, some extremes,
  // the rest anywhere in the signed range.
  function automatic logic signed [DATA_W-1:0] pick_priority();
    int r;
    int step;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      step = $urandom_range(0, 4);
      return (step - 2) * 65536;
    end
    if (r < 36) return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
    return $urandom;
  endfunction

  // Payloads: occasionally null or all ones.
  function automatic logic [DATA_W-1:0] pick_payload();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return '0;
    if (r < 8) return 32'hFFFF_FFFF;
    return $urandom;
  endfunction

  // Receiver stall: random runs of ready and stalled cycles; at most one
  // assignment to out_stall per edge.
  always @(posedge clk) begin
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      out_stall <= !rx_quiet && ($urandom_range(0, 99) < 40);
      rx_hold   <= idle_len();
    end
  end

  // One operation transaction. Returns in the step of the accepting edge,
  // with in_valid still high so a back-to-back transaction follows without
  // a dip.
  task automatic issue_op(input op_kind_t k, input logic [DATA_W-1:0] pay,
                          input logic signed [DATA_W-1:0] pri);
    int unsigned gap;
    in_item_t    op;
    gap = tx_quiet ? 0 : idle_len();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    op.kind         = k;
    op.payload      = pay;
    op.priority_req = pri;
    in_data  <= op;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  // Hold the sender off until every result has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned insert_pct;
    op_kind_t    k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // --- directed ---
    // delete on an empty table, null insert
    issue_op(OP_DELETE, 32'h0000_0000, 32'sh0);
    issue_op(OP_INSERT, 32'h0000_0000, 32'sh7FFF_FFFF);
    // fill every slot: extreme payloads and priorities, a tie on the maximum
    issue_op(OP_INSERT, 32'hFFFF_FFFF, 32'sh8000_0000);
    issue_op(OP_INSERT, 32'h0000_0001, 32'sh7FFF_FFFF);
    issue_op(OP_INSERT, 32'h1111_0002, 32'sh0);
    issue_op(OP_INSERT, 32'h1111_0003, -32'sh1);
    issue_op(OP_INSERT, 32'h1111_0004, 32'sh1);
    issue_op(OP_INSERT, 32'h1111_0005, 32'sh7FFF_FFFF);
    for (int i = 6; i < SLOTS; i++) begin
      issue_op(OP_INSERT, 32'hA000_0000 + i, (i % 3) * 65536);
    end
    // full table: plain insert is dropped, null still reports null first
    issue_op(OP_INSERT, 32'h5555_AAAA, 32'sh7FFF_FFFF);
    issue_op(OP_INSERT, 32'h0000_0000, 32'sh0);
    // pull the top entries, higher slot first on ties
    repeat (5) issue_op(OP_DELETE, 32'hFFFF_FFFF, 32'sh8000_0000);

    // --- random ---
    // Blocks with a fill bias of mostly deletes, balanced or mostly inserts,
    // so the table keeps swinging between empty and full.
    insert_pct = 50;
    for (int n = 0; n < RAND_OPS; n++) begin
      if (n % BLOCK_LEN == 0) begin
        case ($urandom_range(0, 2))
          0: begin
            insert_pct = 15;
          end
          1: begin
            insert_pct = 50;
          end
          default: begin
            insert_pct = 85;
          end
        endcase
        tx_quiet  = ($urandom_range(0, 3) == 0);
        rx_quiet <= ($urandom_range(0, 3) == 0);
      end
      if (n == RAND_OPS / 2) drain_results();
      k = ($urandom_range(0, 99) < insert_pct) ? OP_INSERT : OP_DELETE;
      issue_op(k, pick_payload(), pick_priority());
    end

    // --- wind down ---
    drain_results();
    repeat (SLOTS + 8) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog, several times the slowest legal run.
  initial begin
    #8_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
